FILE: src/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, masked while reset is active.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Implication checked in the next cycle, masked while reset is active.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication through reset");

`endif

FILE: src/taeb_pkg.sv
package taeb_pkg;

    localparam int KEY_W  = 32;
    localparam int CFG_W  = 17;
    localparam int BIN_W  = 16;
    localparam int LEN_W  = 17;
    localparam int DEN_W  = 18;
    localparam int CIDX_W = 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FPTR_W     = 2;
    localparam int FCNT_W     = 3;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SAMPLE_COUNT = 1'b0,
        CFG_BIN_TARGET   = 1'b1
    } taeb_cfg_idx_t;

    // One closed run on its way to the bin decision unit.
    typedef struct packed {
        logic [LEN_W-1:0] run_len;
        logic [LEN_W-1:0] run_start;
        logic [LEN_W-1:0] count;
        logic [CFG_W-1:0] target;
        logic [LEN_W-1:0] start_num;
        logic [CFG_W-1:0] start_den;
        logic             first;
        logic             last;
    } taeb_event_t;

endpackage

FILE: src/tie_aware_equipartition_binner.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_sample_key[31:0]
// m_        out        m_valid / m_ready  m_bin_index[15:0], m_run_length[16:0], m_last_run
// cfg_      in         cfg_wr_en          cfg_index[0], cfg_wdata[16:0]
//
// One sample is taken per cycle while s_ready is high; a run result goes from the run
// tracker through the run queue to the bin decision unit and its output register.
// A sample closing two runs queues two results; the bin unit retires one per cycle unless
// its output stalls, so s_ready drops while the 4-entry run queue has fewer than two free slots.
// Synchronous active-low reset; no clearing pass, ready in the first cycle after reset.
module tie_aware_equipartition_binner #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [taeb_pkg::KEY_W-1:0]  s_sample_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [taeb_pkg::BIN_W-1:0]  m_bin_index,
    output logic [taeb_pkg::LEN_W-1:0]  m_run_length,
    output logic                        m_last_run,
    input  logic                        cfg_wr_en,
    input  logic [taeb_pkg::CIDX_W-1:0] cfg_index,
    input  logic [taeb_pkg::CFG_W-1:0]  cfg_wdata
);
    import taeb_pkg::*;

    logic [CFG_W-1:0] sample_count_reg;
    logic [CFG_W-1:0] bin_target_reg;
    logic             accept;
    logic [1:0]       push_cnt;
    taeb_event_t      ev_a, ev_b, head;
    logic             empty, room2, pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= CFG_W'(65536);
            bin_target_reg   <= CFG_W'(2);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata;
                CFG_BIN_TARGET:   bin_target_reg   <= cfg_wdata;
            endcase
        end
    end

    assign s_ready = room2;
    assign accept  = s_valid && s_ready;

    taeb_run_tracker #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .sample_key   (s_sample_key),
        .sample_count (sample_count_reg),
        .bin_target   (bin_target_reg),
        .push_cnt     (push_cnt),
        .ev_a         (ev_a),
        .ev_b         (ev_b)
    );

    taeb_event_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .ev_a     (ev_a),
        .ev_b     (ev_b),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .room2    (room2)
    );

    taeb_bin_unit u_bin (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ev           (head),
        .ev_avail     (!empty),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_bin_index  (m_bin_index),
        .m_run_length (m_run_length),
        .m_last_run   (m_last_run)
    );

endmodule

FILE: src/taeb_run_tracker.sv
module taeb_run_tracker #(
    parameter int MAX_SAMPLES = 65536
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [taeb_pkg::KEY_W-1:0]   sample_key,
    input  logic [taeb_pkg::CFG_W-1:0]   sample_count,
    input  logic [taeb_pkg::CFG_W-1:0]   bin_target,
    output logic [1:0]                   push_cnt,
    output taeb_pkg::taeb_event_t        ev_a,
    output taeb_pkg::taeb_event_t        ev_b
);
    import taeb_pkg::*;

    localparam int LEN_MAX = (1 << LEN_W) - 1;
    localparam int CNT_MAX = (MAX_SAMPLES < LEN_MAX) ? MAX_SAMPLES : LEN_MAX;
    localparam int CW      = $clog2(CNT_MAX + 1);

    logic [KEY_W-1:0] prev_key_reg, prev_key_next;
    logic [CW-1:0]    pend_reg, pend_next;
    logic [CW-1:0]    seen_reg, seen_next;
    logic [CW-1:0]    start_reg, start_next;
    logic             fresh_reg, fresh_next;
    logic [LEN_W-1:0] snum_reg, snum_next;
    logic [CFG_W-1:0] sden_reg, sden_next;

    logic [LEN_W-1:0] n_full;
    logic [CW-1:0]    n;
    logic             seen0;
    logic [CW-1:0]    pend;
    logic             close0;
    logic [CW-1:0]    start_cur;
    logic [CW-1:0]    pend_new;
    logic [CW:0]      seen_new;
    logic             final_hit;
    logic             fresh_now;
    taeb_event_t      ev0, ev1;

    always_comb begin
        if (sample_count == '0) begin
            n_full = LEN_W'(1);
        end else if (32'(sample_count) > CNT_MAX) begin
            n_full = LEN_W'(CNT_MAX);
        end else begin
            n_full = sample_count;
        end
    end
    assign n = n_full[CW-1:0];

    always_comb begin
        seen0     = (seen_reg == '0);
        pend      = seen0 ? '0 : pend_reg;
        close0    = (pend != '0) && (sample_key != prev_key_reg);
        start_cur = ((pend == '0) || close0) ? seen_reg : start_reg;
        pend_new  = (close0 ? '0 : pend) + CW'(1);
        seen_new  = {1'b0, seen_reg} + (CW+1)'(1);
        final_hit = (seen_new >= {1'b0, n});
        fresh_now = seen0 | fresh_reg;
        snum_next = seen0 ? LEN_W'(n) : snum_reg;
        sden_next = seen0 ? bin_target : sden_reg;

        ev0.run_len   = LEN_W'(pend);
        ev0.run_start = LEN_W'(start_reg);
        ev0.count     = LEN_W'(n);
        ev0.target    = bin_target;
        ev0.start_num = snum_next;
        ev0.start_den = sden_next;
        ev0.first     = fresh_now;
        ev0.last      = 1'b0;

        ev1.run_len   = LEN_W'(pend_new);
        ev1.run_start = LEN_W'(start_cur);
        ev1.count     = LEN_W'(n);
        ev1.target    = bin_target;
        ev1.start_num = snum_next;
        ev1.start_den = sden_next;
        ev1.first     = fresh_now & ~close0;
        ev1.last      = 1'b1;

        ev_a     = close0 ? ev0 : ev1;
        ev_b     = ev1;
        push_cnt = accept ? (2'(close0) + 2'(final_hit)) : 2'd0;

        prev_key_next = sample_key;
        pend_next     = final_hit ? '0 : pend_new;
        seen_next     = final_hit ? '0 : seen_new[CW-1:0];
        start_next    = start_cur;
        fresh_next    = final_hit | (fresh_now & ~close0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg <= '0;
            pend_reg     <= '0;
            seen_reg     <= '0;
            start_reg    <= '0;
            fresh_reg    <= 1'b1;
        end else if (accept) begin
            prev_key_reg <= prev_key_next;
            pend_reg     <= pend_next;
            seen_reg     <= seen_next;
            start_reg    <= start_next;
            fresh_reg    <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            snum_reg <= snum_next;
            sden_reg <= sden_next;
        end
    end

endmodule

FILE: src/taeb_event_fifo.sv
module taeb_event_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            push_cnt,
    input  taeb_pkg::taeb_event_t ev_a,
    input  taeb_pkg::taeb_event_t ev_b,
    input  logic                  pop,
    output taeb_pkg::taeb_event_t head,
    output logic                  empty,
    output logic                  room2
);
    import taeb_pkg::*;

    taeb_event_t       mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FPTR_W'(pop);
        cnt_next    = cnt_reg + FCNT_W'(push_cnt) - FCNT_W'(pop);
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign room2 = (cnt_reg <= FCNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= ev_a;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_reg + FPTR_W'(1)] <= ev_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: src/taeb_bin_unit.sv
module taeb_bin_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  taeb_pkg::taeb_event_t      ev,
    input  logic                       ev_avail,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [taeb_pkg::BIN_W-1:0] m_bin_index,
    output logic [taeb_pkg::LEN_W-1:0] m_run_length,
    output logic                       m_last_run
);
    import taeb_pkg::*;

    localparam int PW = LEN_W + 2 + DEN_W;

    logic [BIN_W-1:0]        bin_reg, bin_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [LEN_W-1:0]        num_reg, num_next;
    logic signed [DEN_W-1:0] den_reg, den_next;
    logic                    m_valid_reg, m_valid_next;
    logic [BIN_W-1:0]        m_bin_reg;
    logic [LEN_W-1:0]        m_len_reg;
    logic                    m_last_reg;

    logic [LEN_W-1:0]        h, num;
    logic [BIN_W-1:0]        bin;
    logic signed [DEN_W-1:0] den;
    logic [LEN_W:0]          hs;
    logic signed [LEN_W+1:0] hs_s, h_s;
    logic signed [PW-1:0]    prod_a, prod_b, num_x, diff_a, diff_b;
    logic [PW-1:0]           mag_a, mag_b;
    logic                    sw;
    logic [BIN_W-1:0]        bin_inc;

    assign pop = ev_avail && (!m_valid_reg || m_ready);

    always_comb begin
        // First run of a stream starts from a clean bin
        h   = ev.first ? '0 : fill_reg;
        bin = ev.first ? '0 : bin_reg;
        num = ev.first ? ev.start_num : num_reg;
        den = ev.first ? $signed({1'b0, ev.start_den}) : den_reg;

        hs     = {1'b0, h} + {1'b0, ev.run_len};
        hs_s   = $signed({1'b0, hs});
        h_s    = $signed({2'b00, h});
        prod_a = PW'(hs_s) * PW'(den);
        prod_b = PW'(h_s) * PW'(den);
        num_x  = $signed({{(PW-LEN_W){1'b0}}, num});
        diff_a = prod_a - num_x;
        diff_b = prod_b - num_x;
        mag_a  = diff_a[PW-1] ? PW'(-diff_a) : PW'(diff_a);
        mag_b  = diff_b[PW-1] ? PW'(-diff_b) : PW'(diff_b);
        sw     = (h != '0) && (mag_a >= mag_b);

        bin_inc = (bin == {BIN_W{1'b1}}) ? bin : bin + BIN_W'(1);

        if (sw) begin
            bin_next  = bin_inc;
            num_next  = (ev.count > ev.run_start) ? ev.count - ev.run_start : '0;
            den_next  = $signed({1'b0, ev.target}) - $signed({2'b00, bin_inc});
            fill_next = ev.run_len;
        end else begin
            bin_next  = bin;
            num_next  = num;
            den_next  = den;
            fill_next = hs[LEN_W-1:0];
        end

        if (pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg     <= '0;
            fill_reg    <= '0;
            num_reg     <= '0;
            den_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                bin_reg  <= bin_next;
                fill_reg <= fill_next;
                num_reg  <= num_next;
                den_reg  <= den_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_bin_reg  <= bin_next;
            m_len_reg  <= ev.run_len;
            m_last_reg <= ev.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_bin_index  = m_bin_reg;
    assign m_run_length = m_len_reg;
    assign m_last_run   = m_last_reg;

endmodule

FILE: src/taeb_checker.sv
`include "assert_macros.svh"

module taeb_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [taeb_pkg::BIN_W-1:0] m_bin_index,
    input logic [taeb_pkg::LEN_W-1:0] m_run_length,
    input logic                       m_last_run
);
    import taeb_pkg::*;

    logic [BIN_W-1:0]       prev_bin_reg;
    logic                   in_stream_reg, in_stream_next;
    logic [BIN_W+LEN_W:0]   m_payload;
    logic                   bin_step_ok;

    assign m_payload   = {m_bin_index, m_run_length, m_last_run};
    assign bin_step_ok = (m_bin_index == prev_bin_reg) ||
                         (m_bin_index == prev_bin_reg + BIN_W'(1));

    // Tracks whether the next result continues a stream already under way
    always_comb begin
        if (m_valid && m_ready) begin
            in_stream_next = !m_last_run;
        end else begin
            in_stream_next = in_stream_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_stream_reg <= 1'b0;
        end else begin
            in_stream_reg <= in_stream_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            prev_bin_reg <= m_bin_index;
        end
    end

    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid)
    `ASSERT_IMP(a_run_nonzero, aclk, aresetn, m_valid, m_run_length != '0)
    `ASSERT_IMP(a_stream_bin0, aclk, aresetn, m_valid && !in_stream_reg, m_bin_index == '0)
    `ASSERT_IMP(a_bin_step, aclk, aresetn, m_valid && in_stream_reg, bin_step_ok)

endmodule

bind tie_aware_equipartition_binner taeb_checker u_taeb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_bin_index  (m_bin_index),
    .m_run_length (m_run_length),
    .m_last_run   (m_last_run)
);
